@@ rtl/fdp_pkg.sv @@
// shared types, constants and control codes of the float dot product accumulator
package fdp_pkg;

	typedef logic [31:0] f32_t;

	localparam int LANES              = 4;
	localparam int ACC_GROUPS_DEFAULT = 8;
	localparam int FMA_LAT            = 8;

	localparam f32_t F32_QNAN = 32'h7FC0_0000;
	localparam f32_t F32_ONE  = 32'h3F80_0000;
	localparam f32_t F32_INF  = 32'h7F80_0000;
	localparam f32_t F32_ZERO = 32'h0000_0000;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_CHECK,
		ST_PAIR,
		ST_WAIT,
		ST_OUT
	} merge_state_t;

	typedef struct packed {
		logic run;
		logic snap;
		logic issue;
		logic load_out;
	} merge_ctl_t;

endpackage

@@ rtl/fdp_fma.sv @@
// pipelined single precision fused multiply-add, round to nearest even
module fdp_fma (
	input  logic          clk,
	input  fdp_pkg::f32_t a,
	input  fdp_pkg::f32_t b,
	input  fdp_pkg::f32_t c,
	output fdp_pkg::f32_t r
);

	function automatic logic [5:0] msb_idx(input logic [62:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 63; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	// stage 1: classify, unpack, multiply
	logic              nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, za, zb, zc, sp, sc;
	logic [23:0]       ma, mb, mc;
	logic signed [9:0] ea, eb, ec;
	logic              spec;
	fdp_pkg::f32_t     spec_val;

	always_comb begin
		nan_a = (&a[30:23]) && (|a[22:0]);
		nan_b = (&b[30:23]) && (|b[22:0]);
		nan_c = (&c[30:23]) && (|c[22:0]);
		inf_a = a[30:0] == fdp_pkg::F32_INF[30:0];
		inf_b = b[30:0] == fdp_pkg::F32_INF[30:0];
		inf_c = c[30:0] == fdp_pkg::F32_INF[30:0];
		za    = a[30:0] == 31'd0;
		zb    = b[30:0] == 31'd0;
		zc    = c[30:0] == 31'd0;
		sp    = a[31] ^ b[31];
		sc    = c[31];
		ma    = {|a[30:23], a[22:0]};
		mb    = {|b[30:23], b[22:0]};
		mc    = {|c[30:23], c[22:0]};
		ea    = (a[30:23] == 8'd0) ? -10'sd149 : $signed({2'b00, a[30:23]}) - 10'sd150;
		eb    = (b[30:23] == 8'd0) ? -10'sd149 : $signed({2'b00, b[30:23]}) - 10'sd150;
		ec    = (c[30:23] == 8'd0) ? -10'sd149 : $signed({2'b00, c[30:23]}) - 10'sd150;
		spec     = 1'b1;
		spec_val = fdp_pkg::F32_QNAN;
		if (nan_a || nan_b || nan_c) begin
			spec_val = fdp_pkg::F32_QNAN;
		end else if (inf_a || inf_b) begin
			if (za || zb) spec_val = fdp_pkg::F32_QNAN;
			else if (inf_c && (sc != sp)) spec_val = fdp_pkg::F32_QNAN;
			else spec_val = {sp, fdp_pkg::F32_INF[30:0]};
		end else if (inf_c) begin
			spec_val = c;
		end else if (za || zb) begin
			spec_val = zc ? {sp & sc, 31'd0} : c;
		end else begin
			spec = 1'b0;
		end
	end

	logic [47:0]       prod_s1;
	logic signed [9:0] ep_s1, ec_s1;
	logic [23:0]       mc_s1;
	logic              sp_s1, sc_s1, zc_s1, spec_s1;
	fdp_pkg::f32_t     sv_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= 48'(ma) * 48'(mb);
		ep_s1   <= ea + eb;
		ec_s1   <= ec;
		mc_s1   <= mc;
		sp_s1   <= sp;
		sc_s1   <= sc;
		zc_s1   <= zc;
		spec_s1 <= spec;
		sv_s1   <= spec_val;
	end

	// stage 2: normalize both terms to bit 61
	logic [5:0] pp, pc;
	assign pp = msb_idx({15'd0, prod_s1});
	assign pc = msb_idx({39'd0, mc_s1});

	logic [61:0]       mp_s2, mc_s2;
	logic signed [9:0] ep_s2, ec_s2;
	logic              sp_s2, sc_s2, zc_s2, spec_s2;
	fdp_pkg::f32_t     sv_s2;

	always_ff @(posedge clk) begin
		mp_s2   <= {14'd0, prod_s1} << (6'd61 - pp);
		mc_s2   <= {38'd0, mc_s1} << (6'd61 - pc);
		ep_s2   <= ep_s1 + $signed({4'd0, pp}) - 10'sd61;
		ec_s2   <= ec_s1 + $signed({4'd0, pc}) - 10'sd61;
		sp_s2   <= sp_s1;
		sc_s2   <= sc_s1;
		zc_s2   <= zc_s1;
		spec_s2 <= spec_s1;
		sv_s2   <= sv_s1;
	end

	// stage 3: order by magnitude
	logic               swap;
	logic [61:0]        mbig, msml;
	logic signed [9:0]  ebig, esml;
	logic signed [10:0] dexp;

	always_comb begin
		swap = !zc_s2 && ((ep_s2 < ec_s2) || ((ep_s2 == ec_s2) && (mp_s2 < mc_s2)));
		mbig = swap ? mc_s2 : mp_s2;
		msml = swap ? mp_s2 : mc_s2;
		ebig = swap ? ec_s2 : ep_s2;
		esml = swap ? ep_s2 : ec_s2;
		dexp = 11'(ebig) - 11'(esml);
	end

	logic [61:0]       mbig_s3, msml_s3;
	logic signed [9:0] e_s3;
	logic [5:0]        d_s3;
	logic              s_s3, same_s3, spec_s3;
	fdp_pkg::f32_t     sv_s3;

	always_ff @(posedge clk) begin
		mbig_s3 <= mbig;
		msml_s3 <= msml;
		e_s3    <= ebig;
		d_s3    <= (dexp > 11'sd63) ? 6'd63 : dexp[5:0];
		s_s3    <= swap ? sc_s2 : sp_s2;
		same_s3 <= sp_s2 == sc_s2;
		spec_s3 <= spec_s2;
		sv_s3   <= sv_s2;
	end

	// stage 4: align the smaller term, shifted-out bits fold into bit 0
	logic [61:0] lost_mask;
	assign lost_mask = ~({62{1'b1}} << d_s3);

	logic [61:0]       mbig_s4, malg_s4;
	logic signed [9:0] e_s4;
	logic              s_s4, same_s4, spec_s4;
	fdp_pkg::f32_t     sv_s4;

	always_ff @(posedge clk) begin
		mbig_s4 <= mbig_s3;
		malg_s4 <= (msml_s3 >> d_s3) | {61'd0, |(msml_s3 & lost_mask)};
		e_s4    <= e_s3;
		s_s4    <= s_s3;
		same_s4 <= same_s3;
		spec_s4 <= spec_s3;
		sv_s4   <= sv_s3;
	end

	// stage 5: add or subtract, exact cancellation gives +0
	logic [62:0]       sum_s5;
	logic signed [9:0] e_s5;
	logic              s_s5, z_s5, spec_s5;
	fdp_pkg::f32_t     sv_s5;

	always_ff @(posedge clk) begin
		sum_s5  <= same_s4 ? ({1'b0, mbig_s4} + {1'b0, malg_s4})
		                   : ({1'b0, mbig_s4} - {1'b0, malg_s4});
		z_s5    <= !same_s4 && (mbig_s4 == malg_s4);
		e_s5    <= e_s4;
		s_s5    <= s_s4;
		spec_s5 <= spec_s4;
		sv_s5   <= sv_s4;
	end

	// stage 6: leading one of the sum
	logic [62:0]       sum_s6;
	logic [5:0]        t_s6;
	logic signed [9:0] e_s6;
	logic              s_s6, z_s6, spec_s6;
	fdp_pkg::f32_t     sv_s6;

	always_ff @(posedge clk) begin
		sum_s6  <= sum_s5;
		t_s6    <= msb_idx(sum_s5);
		e_s6    <= e_s5;
		s_s6    <= s_s5;
		z_s6    <= z_s5;
		spec_s6 <= spec_s5;
		sv_s6   <= sv_s5;
	end

	// stage 7: pick the result exponent and cut the mantissa
	logic signed [10:0] q_raw, q_cl, shv, shl;
	logic [5:0]         shr;
	logic [62:0]        lo_mask;
	logic [23:0]        mant_pre;
	logic               guard, sticky;

	always_comb begin
		q_raw   = $signed({5'd0, t_s6}) + 11'(e_s6) - 11'sd23;
		q_cl    = (q_raw < -11'sd149) ? -11'sd149 : q_raw;
		shv     = q_cl - 11'(e_s6);
		shl     = -shv;
		shr     = shv[5:0];
		lo_mask = ~({63{1'b1}} << (shr - 6'd1));
		mant_pre = '0;
		guard    = 1'b0;
		sticky   = 1'b0;
		if (shv <= 11'sd0) begin
			mant_pre = 24'(sum_s6 << shl[4:0]);
		end else if (shv < 11'sd64) begin
			mant_pre = 24'(sum_s6 >> shr);
			guard    = sum_s6[shr - 6'd1];
			sticky   = |(sum_s6 & lo_mask);
		end
	end

	logic [23:0]        mant_s7;
	logic               rnd_s7;
	logic signed [10:0] q_s7;
	logic               s_s7, z_s7, spec_s7;
	fdp_pkg::f32_t      sv_s7;

	always_ff @(posedge clk) begin
		mant_s7 <= mant_pre;
		rnd_s7  <= guard && (sticky || mant_pre[0]);
		q_s7    <= q_cl;
		s_s7    <= s_s6;
		z_s7    <= z_s6;
		spec_s7 <= spec_s6;
		sv_s7   <= sv_s6;
	end

	// stage 8: round up, renormalize on carry, pack
	logic [24:0]        mant_r;
	logic [23:0]        mant_n;
	logic signed [10:0] q_n, be;
	fdp_pkg::f32_t      packed_val;

	always_comb begin
		mant_r = {1'b0, mant_s7} + {24'd0, rnd_s7};
		mant_n = mant_r[24] ? 24'h80_0000 : mant_r[23:0];
		q_n    = mant_r[24] ? q_s7 + 11'sd1 : q_s7;
		be     = q_n + 11'sd150;
		if (!mant_n[23]) packed_val = {s_s7, 8'd0, mant_n[22:0]};
		else if (be >= 11'sd255) packed_val = {s_s7, fdp_pkg::F32_INF[30:0]};
		else packed_val = {s_s7, be[7:0], mant_n[22:0]};
	end

	always_ff @(posedge clk) begin
		if (spec_s7) r <= sv_s7;
		else if (z_s7) r <= fdp_pkg::F32_ZERO;
		else r <= packed_val;
	end

endmodule

@@ rtl/fdp_merge.sv @@
// merging sequencer: pairwise reduction of the accumulator groups and then of the lanes
module fdp_merge #(
	parameter int ACC_GROUPS = fdp_pkg::ACC_GROUPS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 last_acc,
	input  logic                 pipe_empty,
	input  logic                 out_free,
	input  fdp_pkg::f32_t        acc [ACC_GROUPS][fdp_pkg::LANES],
	input  logic                 ret_vld,
	input  logic [$clog2((ACC_GROUPS > fdp_pkg::LANES) ? ACC_GROUPS : fdp_pkg::LANES)-1:0] ret_dst,
	input  fdp_pkg::f32_t        ret_val [fdp_pkg::LANES],
	output fdp_pkg::merge_ctl_t  ctl,
	output logic [$clog2((ACC_GROUPS > fdp_pkg::LANES) ? ACC_GROUPS : fdp_pkg::LANES)-1:0] iss_dst,
	output fdp_pkg::f32_t        opa [fdp_pkg::LANES],
	output fdp_pkg::f32_t        opc [fdp_pkg::LANES],
	output fdp_pkg::f32_t        sum_val
);

	localparam int LANES = fdp_pkg::LANES;
	localparam int D     = (ACC_GROUPS > LANES) ? ACC_GROUPS : LANES;
	localparam int DW    = $clog2(D);
	localparam int WW    = $clog2(D + 1);

	fdp_pkg::merge_state_t state_q, state_nx;
	fdp_pkg::f32_t         sh_q  [D][LANES];
	fdp_pkg::f32_t         col_q [D][LANES];
	logic [WW-1:0]         w_q;
	logic [DW-1:0]         i_q;
	logic                  lane_ph_q;
	logic [WW-1:0]         half_w;

	assign half_w = w_q >> 1;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			fdp_pkg::ST_RUN:   if (last_acc) state_nx = fdp_pkg::ST_DRAIN;
			fdp_pkg::ST_DRAIN: if (pipe_empty) state_nx = fdp_pkg::ST_CHECK;
			fdp_pkg::ST_CHECK: begin
				if (w_q != WW'(1)) state_nx = fdp_pkg::ST_PAIR;
				else if (lane_ph_q) state_nx = fdp_pkg::ST_OUT;
			end
			fdp_pkg::ST_PAIR:  if (WW'(i_q) == half_w - WW'(1)) state_nx = fdp_pkg::ST_WAIT;
			fdp_pkg::ST_WAIT:  if (pipe_empty) state_nx = fdp_pkg::ST_CHECK;
			fdp_pkg::ST_OUT:   if (out_free) state_nx = fdp_pkg::ST_RUN;
			default:           state_nx = fdp_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		ctl.run      = state_q == fdp_pkg::ST_RUN;
		ctl.snap     = (state_q == fdp_pkg::ST_DRAIN) && pipe_empty;
		ctl.issue    = state_q == fdp_pkg::ST_PAIR;
		ctl.load_out = (state_q == fdp_pkg::ST_OUT) && out_free;
		iss_dst      = i_q;
		sum_val      = sh_q[0][0];
		for (int l = 0; l < LANES; l++) begin
			opa[l] = sh_q[0][l];
			opc[l] = sh_q[1][l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fdp_pkg::ST_RUN;
			w_q       <= '0;
			i_q       <= '0;
			lane_ph_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				fdp_pkg::ST_DRAIN: begin
					if (pipe_empty) begin
						w_q       <= WW'(ACC_GROUPS);
						lane_ph_q <= 1'b0;
					end
				end
				fdp_pkg::ST_CHECK: begin
					i_q <= '0;
					if (w_q == WW'(1) && !lane_ph_q) begin
						w_q       <= WW'(LANES);
						lane_ph_q <= 1'b1;
					end
				end
				fdp_pkg::ST_PAIR:  i_q <= i_q + 1'b1;
				fdp_pkg::ST_WAIT:  if (pipe_empty) w_q <= (w_q + WW'(1)) >> 1;
				default: begin
				end
			endcase
		end
	end

	// working rows: loaded from the accumulators, consumed two at a time from the front
	always_ff @(posedge clk) begin
		if (state_q == fdp_pkg::ST_DRAIN && pipe_empty) begin
			for (int k = 0; k < ACC_GROUPS; k++) begin
				for (int l = 0; l < LANES; l++) sh_q[k][l] <= acc[k][l];
			end
		end else if (state_q == fdp_pkg::ST_CHECK && w_q == WW'(1) && !lane_ph_q) begin
			// transpose the group total so lane k sits in row k
			for (int k = 0; k < LANES; k++) sh_q[k][0] <= sh_q[0][k];
		end else if (state_q == fdp_pkg::ST_PAIR) begin
			for (int k = 0; k < D - 2; k++) sh_q[k] <= sh_q[k + 2];
		end else if (state_q == fdp_pkg::ST_WAIT && pipe_empty) begin
			for (int k = 0; k < D; k++) begin
				if (WW'(k) < half_w) sh_q[k] <= col_q[k];
				else if (WW'(k) == half_w && w_q[0]) sh_q[k] <= sh_q[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ret_vld) col_q[ret_dst] <= ret_val;
	end

endmodule

@@ rtl/float_dot_product_accumulator.sv @@
// top level of the single precision dot product accumulator
//
// usage
//   request channel: item_valid / item_stall carry four x,y pairs, valid_pairs and is_last;
//   a request is taken at a rising edge with item_valid high and item_stall low
//   result channel: sum_valid / sum_stall carry dot_sum, one result per request marked last
//   lane l of request j is fused-multiply-added into accumulator (j mod ACC_GROUPS, l);
//   lanes at or above valid_pairs leave their accumulator alone
//   throughput: one request per cycle inside a vector; the loop through the 8-stage
//   fused multiply-add unit and the accumulator group interleave set this, so with
//   fewer than 8 groups a request waits until its group's previous update has left the unit
//   end of vector: after a request marked last the block drains the lane units, then
//   reduces groups and lanes pairwise on the same units, one tree level at a time, and
//   loads the output register; requests are held off with item_stall during that time
//   a stalled result stays in the output register while a new vector streams in;
//   a second end of vector waits until that register is free
//   reset: all accumulators read +0.0, group pointer 0, no result pending
module float_dot_product_accumulator #(
	parameter int ACC_GROUPS = fdp_pkg::ACC_GROUPS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [31:0] x_lane0,
	input  logic [31:0] x_lane1,
	input  logic [31:0] x_lane2,
	input  logic [31:0] x_lane3,
	input  logic [31:0] y_lane0,
	input  logic [31:0] y_lane1,
	input  logic [31:0] y_lane2,
	input  logic [31:0] y_lane3,
	input  logic [2:0]  valid_pairs,
	input  logic        is_last,
	output logic        sum_valid,
	input  logic        sum_stall,
	output logic [31:0] dot_sum
);

	localparam int LANES = fdp_pkg::LANES;
	localparam int LAT   = fdp_pkg::FMA_LAT;
	localparam int D     = (ACC_GROUPS > LANES) ? ACC_GROUPS : LANES;
	localparam int DW    = $clog2(D);
	localparam int GW    = (ACC_GROUPS > 1) ? $clog2(ACC_GROUPS) : 1;

	// bookkeeping that travels alongside the lane units
	typedef struct packed {
		logic             vld;
		logic             red;
		logic [GW-1:0]    grp;
		logic [LANES-1:0] en;
		logic [DW-1:0]    dst;
	} tag_t;

	fdp_pkg::f32_t       xin [LANES];
	fdp_pkg::f32_t       yin [LANES];
	fdp_pkg::f32_t       fa [LANES];
	fdp_pkg::f32_t       fb [LANES];
	fdp_pkg::f32_t       fc [LANES];
	fdp_pkg::f32_t       fr [LANES];
	fdp_pkg::f32_t       opa [LANES];
	fdp_pkg::f32_t       opc [LANES];
	fdp_pkg::f32_t       acc_q [ACC_GROUPS][LANES];
	fdp_pkg::f32_t       sum_val;
	fdp_pkg::merge_ctl_t ctl;
	logic [DW-1:0]       iss_dst;
	logic [GW-1:0]       grp_q;
	tag_t                tag_q [LAT];
	tag_t                tag_in, tag_wb;
	logic [LANES-1:0]    en_vec;
	logic                hazard, pipe_empty, accept, out_free;
	logic                sum_valid_q;
	logic [31:0]         dot_sum_q;

	assign xin[0] = x_lane0;
	assign xin[1] = x_lane1;
	assign xin[2] = x_lane2;
	assign xin[3] = x_lane3;
	assign yin[0] = y_lane0;
	assign yin[1] = y_lane1;
	assign yin[2] = y_lane2;
	assign yin[3] = y_lane3;

	// lane enables, a count above the lane count means all lanes
	always_comb begin
		for (int l = 0; l < LANES; l++) en_vec[l] = valid_pairs > 3'(l);
	end

	assign tag_wb = tag_q[LAT-1];

	// a request must not read a group whose update is still inside the unit;
	// the update leaving the unit this cycle is forwarded instead
	always_comb begin
		hazard     = 1'b0;
		pipe_empty = 1'b1;
		for (int k = 0; k < LAT - 1; k++) begin
			if (tag_q[k].vld && !tag_q[k].red && tag_q[k].grp == grp_q) hazard = 1'b1;
		end
		for (int k = 0; k < LAT; k++) begin
			if (tag_q[k].vld) pipe_empty = 1'b0;
		end
	end

	assign item_stall = !ctl.run || hazard;
	assign accept     = item_valid && !item_stall;
	assign out_free   = !sum_valid_q || !sum_stall;

	// operand select: streaming requests or reduction adds (x * 1.0 + y)
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (ctl.issue) begin
				fa[l] = opa[l];
				fb[l] = fdp_pkg::F32_ONE;
				fc[l] = opc[l];
			end else begin
				fa[l] = xin[l];
				fb[l] = yin[l];
				if (tag_wb.vld && !tag_wb.red && tag_wb.grp == grp_q && tag_wb.en[l]) begin
					fc[l] = fr[l];
				end else begin
					fc[l] = acc_q[grp_q][l];
				end
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		fdp_fma u_fma (
			.clk (clk),
			.a   (fa[l]),
			.b   (fb[l]),
			.c   (fc[l]),
			.r   (fr[l])
		);
	end

	always_comb begin
		tag_in.vld = accept || ctl.issue;
		tag_in.red = ctl.issue;
		tag_in.grp = grp_q;
		tag_in.en  = ctl.issue ? '1 : en_vec;
		tag_in.dst = iss_dst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) tag_q[k] <= '0;
		end else begin
			tag_q[0] <= tag_in;
			for (int k = 1; k < LAT; k++) tag_q[k] <= tag_q[k-1];
		end
	end

	// accumulators and group pointer; the snapshot for the reduction clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
			for (int g = 0; g < ACC_GROUPS; g++) begin
				for (int l = 0; l < LANES; l++) acc_q[g][l] <= fdp_pkg::F32_ZERO;
			end
		end else if (ctl.snap) begin
			grp_q <= '0;
			for (int g = 0; g < ACC_GROUPS; g++) begin
				for (int l = 0; l < LANES; l++) acc_q[g][l] <= fdp_pkg::F32_ZERO;
			end
		end else begin
			if (accept) grp_q <= (grp_q == GW'(ACC_GROUPS - 1)) ? '0 : grp_q + 1'b1;
			if (tag_wb.vld && !tag_wb.red) begin
				for (int l = 0; l < LANES; l++) begin
					if (tag_wb.en[l]) acc_q[tag_wb.grp][l] <= fr[l];
				end
			end
		end
	end

	fdp_merge #(
		.ACC_GROUPS (ACC_GROUPS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.last_acc   (accept && is_last),
		.pipe_empty (pipe_empty),
		.out_free   (out_free),
		.acc        (acc_q),
		.ret_vld    (tag_wb.vld && tag_wb.red),
		.ret_dst    (tag_wb.dst),
		.ret_val    (fr),
		.ctl        (ctl),
		.iss_dst    (iss_dst),
		.opa        (opa),
		.opc        (opc),
		.sum_val    (sum_val)
	);

	// output register, holds while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			sum_valid_q <= 1'b1;
		end else if (!sum_stall) begin
			sum_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) dot_sum_q <= sum_val;
	end

	assign sum_valid = sum_valid_q;
	assign dot_sum   = dot_sum_q;

endmodule
